/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL files that check their own behaviour.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, ignored while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hdl/rrca_pkg.sv */
// ----------------------------------------------------------------------------
// rrca_pkg
// Types and constants of the reorder receiver with cumulative ack.
// ----------------------------------------------------------------------------
`default_nettype none

package rrca_pkg;

   localparam int WINDOW      = 32;
   localparam int MAX_RESULTS = 32;
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int SEQ_W       = 16;
   localparam int LEN_W       = 8;
   localparam int REF_W       = 8;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd124;
   localparam logic [SEQ_W-1:0] NEXT_EXP_RESET = 16'd1;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      logic [LEN_W-1:0] payload_len;
      logic [REF_W-1:0] payload_ref;
      logic             check_ok;
   } req_type;

   typedef struct packed {
      logic             deliver;
      logic [SEQ_W-1:0] ack_seq;
      logic [LEN_W-1:0] out_len;
      logic [REF_W-1:0] out_ref;
      logic             last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic drain;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/rrca_ram.sv */
// ----------------------------------------------------------------------------
// rrca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/rrca_ctrl.sv */
// ----------------------------------------------------------------------------
// rrca_ctrl
// Sequencer: accept a packet, classify it, then walk the buffered run.
// ----------------------------------------------------------------------------
`default_nettype none

module rrca_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire rrca_pkg::dp_status_type status,
   output logic                        busy,
   output rrca_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EVAL  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL, ST_DRAIN: begin
            state_in = status.more ? ST_DRAIN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.eval  = (state_ff == ST_EVAL);
   assign cmd.drain = (state_ff == ST_DRAIN);

endmodule

`default_nettype wire

/* hdl/rrca_dp.sv */
// ----------------------------------------------------------------------------
// rrca_dp
// Datapath: window state, slot store, classification and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

module rrca_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rrca_pkg::ctrl_cmd_type          cmd,
   input  wire rrca_pkg::req_type               req_item,
   input  wire logic                            csr_wr_en,
   input  wire logic [rrca_pkg::LEN_W-1:0]      csr_wr_data,
   output rrca_pkg::dp_status_type              status,
   output logic                                 rsp_valid,
   output rrca_pkg::rsp_type                    rsp_item
);

   localparam int SW = rrca_pkg::SLOT_W;
   localparam int CW = rrca_pkg::CNT_W;
   localparam int QW = rrca_pkg::SEQ_W;

   rrca_pkg::req_type              req_ff;
   logic [rrca_pkg::LEN_W-1:0]     max_len_ff;
   logic [QW-1:0]                  next_exp_ff, next_exp_in;
   logic [SW-1:0]                  exp_slot_ff, exp_slot_in;
   logic [rrca_pkg::WINDOW-1:0]    valid_ff;
   logic [CW-1:0]                  cnt_ff, cnt_in;

   logic [QW-1:0]  seq_dist;
   logic           len_ok, in_order, future, wrapped, step;
   logic [SW:0]    slot_sum;
   logic [SW-1:0]  seq_slot, slot_inc;
   logic [rrca_pkg::LEN_W+rrca_pkg::REF_W-1:0] rd_data;

   // classification of the latched packet
   assign seq_dist = req_ff.seq_num - next_exp_ff;
   assign len_ok   = req_ff.check_ok && (req_ff.payload_len != '0)
                     && (req_ff.payload_len <= max_len_ff);
   assign in_order = len_ok && (seq_dist == '0);
   assign future   = len_ok && (seq_dist != '0) && (seq_dist < QW'(rrca_pkg::WINDOW));

   // seq mod window: from the expected slot plus distance, or directly
   // when the sequence number wrapped past zero
   assign wrapped  = (req_ff.seq_num < next_exp_ff);
   assign slot_sum = {1'b0, exp_slot_ff} + {1'b0, seq_dist[SW-1:0]};
   always_comb begin
      if (wrapped) begin
         seq_slot = req_ff.seq_num[SW-1:0];
      end else if (slot_sum >= (SW+1)'(rrca_pkg::WINDOW)) begin
         seq_slot = SW'(slot_sum - (SW+1)'(rrca_pkg::WINDOW));
      end else begin
         seq_slot = slot_sum[SW-1:0];
      end
   end

   always_comb begin
      if (next_exp_ff == '1) begin
         slot_inc = '0;
      end else if (exp_slot_ff == SW'(rrca_pkg::WINDOW - 1)) begin
         slot_inc = '0;
      end else begin
         slot_inc = exp_slot_ff + SW'(1);
      end
   end

   assign step        = (cmd.eval && in_order) || cmd.drain;
   assign next_exp_in = step ? next_exp_ff + QW'(1) : next_exp_ff;
   assign exp_slot_in = step ? slot_inc : exp_slot_ff;
   assign cnt_in      = cmd.eval ? CW'(1) : cnt_ff + CW'(1);
   assign status.more = step && (cnt_in < CW'(rrca_pkg::MAX_RESULTS)) && valid_ff[slot_inc];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= rrca_pkg::MAX_LEN_RESET;
         next_exp_ff <= rrca_pkg::NEXT_EXP_RESET;
         exp_slot_ff <= SW'(rrca_pkg::NEXT_EXP_RESET % rrca_pkg::WINDOW);
         valid_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         next_exp_ff <= next_exp_in;
         exp_slot_ff <= exp_slot_in;
         if (cmd.eval || cmd.drain) begin
            cnt_ff <= cnt_in;
         end
         if (step) begin
            valid_ff[exp_slot_ff] <= 1'b0;
         end
         if (cmd.eval && future) begin
            valid_ff[seq_slot] <= 1'b1;
         end
      end
   end

   // read address is the next expected slot, so the registered read data is ready for the walk
   rrca_ram #(
      .WIDTH (rrca_pkg::LEN_W + rrca_pkg::REF_W),
      .DEPTH (rrca_pkg::WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.eval && future),
      .wr_addr (seq_slot),
      .wr_data ({req_ff.payload_len, req_ff.payload_ref}),
      .rd_addr (exp_slot_in),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid        = cmd.eval || cmd.drain;
      rsp_item.deliver = 1'b0;
      rsp_item.ack_seq = next_exp_ff - QW'(1);
      rsp_item.out_len = '0;
      rsp_item.out_ref = '0;
      rsp_item.last    = !status.more;
      if (cmd.drain) begin
         rsp_item.deliver = 1'b1;
         rsp_item.ack_seq = next_exp_ff;
         rsp_item.out_len = rd_data[rrca_pkg::LEN_W+rrca_pkg::REF_W-1:rrca_pkg::REF_W];
         rsp_item.out_ref = rd_data[rrca_pkg::REF_W-1:0];
      end else if (in_order) begin
         rsp_item.deliver = 1'b1;
         rsp_item.ack_seq = next_exp_ff;
         rsp_item.out_len = req_ff.payload_len;
         rsp_item.out_ref = req_ff.payload_ref;
      end
   end

endmodule

`default_nettype wire

/* hdl/reorder_receiver_cumulative_ack.sv */
// ----------------------------------------------------------------------------
// reorder_receiver_cumulative_ack
// Receive window that buffers out-of-order packets and delivers in order.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_item      taken when start high and busy low
//  response  rsp_valid, rsp_item        one beat per cycle, cannot be stalled
//  csr       csr_wr_en, csr_wr_data     max_length written when csr_wr_en high
//
//  a packet is latched on acceptance, then classified in ST_EVAL, which emits the first beat
//  each buffered packet released by an in-order arrival adds a drain beat,
//  one beat a cycle from the slot RAM, up to MAX_RESULTS beats per packet
//  busy stays high until the last beat has been emitted
//  synchronous reset; no clearing pass, slot valid bits are flops
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module reorder_receiver_cumulative_ack (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire rrca_pkg::req_type           req_item,
   output logic                             rsp_valid,
   output rrca_pkg::rsp_type                rsp_item,
   input  wire logic                        csr_wr_en,
   input  wire logic [rrca_pkg::LEN_W-1:0]  csr_wr_data
);

   rrca_pkg::ctrl_cmd_type  cmd;
   rrca_pkg::dp_status_type status;

   rrca_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   rrca_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

   // every accepted packet answers on the next cycle
   `ASSERT_NEXT(a_first_beat, clock, reset, start && !busy, rsp_valid)
   // beats only come out while a packet is in hand
   `ASSERT_IMPLY(a_beat_busy, clock, reset, rsp_valid, busy)
   // a non-final beat is always followed by another
   `ASSERT_NEXT(a_walk_cont, clock, reset, rsp_valid && !rsp_item.last, rsp_valid)
   // the final beat frees the block
   `ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && rsp_item.last, !busy)
   // an ack-only beat ends the packet
   `ASSERT_IMPLY(a_ack_last, clock, reset, rsp_valid && !rsp_item.deliver, rsp_item.last)

endmodule

`default_nettype wire
